// ===== design/qvr_pkg.sv =====
// Package for the quaternion vector rotation block: default widths and
// divider step count. No dependencies.
package qvr_pkg;

  // default width of every data field
  localparam int unsigned DATA_WIDTH_DEF = 16;

  // quotient bits resolved per divider pipeline stage
  localparam int unsigned DIV_STEPS = 2;

  // number of flags in the result tuser
  localparam int unsigned USER_WIDTH = 2;

  // tuser bit positions of the result flags
  localparam int unsigned USER_ZERO_BIT = 0;
  localparam int unsigned USER_SAT_BIT  = 1;

endpackage

// ===== design/quaternion_vector_rotate.sv =====
// Quaternion vector rotation, fully pipelined top level.
// Depends on qvr_pkg for defaults and the divider step count.

// Rotates the 3-vector v by the quaternion q = (x, y, z, w) as
// q (v,0) conj(q) / |q|^2, rounds each component to nearest (ties away from
// zero) and saturates it to DATA_WIDTH signed bits. The quaternion scale does
// not matter, so any Q format of q gives the same result. One item enters per
// cycle while the pipeline is not full and blocked at the output. The item
// passes 6 + ceil(DATA_WIDTH / 2) register stages: four multiply/add stages, a
// sign/magnitude stage, the restoring divider that resolves two quotient bits
// per stage, and the round/saturate stage. Each stage holds only while it is
// full and the stage after it is blocked, so bubbles close up and the input
// keeps accepting while a result waits at the output. A quaternion of all
// zeros raises zero_quaternion with zero outputs; saturated marks any clipped
// component.
module quaternion_vector_rotate #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z from bit 0 up
  input  logic [((7*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // out_x, out_y, out_z from bit 0 up
  output logic [((3*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // zero_quaternion, saturated from bit 0 up
  output logic [qvr_pkg::USER_WIDTH-1:0]         m_axis_tuser
);

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned PW    = 2 * DW;          // one product of two fields
  localparam int unsigned DENW  = 2 * DW + 2;      // modulus and its relatives
  localparam int unsigned NW    = 3 * DW + 4;      // numerator
  localparam int unsigned MW    = 3 * DW + 2;      // second-level products
  localparam int unsigned STEPS = qvr_pkg::DIV_STEPS;
  localparam int unsigned NDS   = (DW + STEPS - 1) / STEPS;
  localparam int unsigned NS    = 5 + NDS + 1;     // total register stages

  // stage enables: a stage loads when empty or when its successor loads
  logic [NS:0]   en;
  logic [NS-1:0] vld_q, vld_d;

  always_comb begin
    en[NS] = m_axis_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];

  // unpack the input item: quaternion x, y, z, w then vector x, y, z
  logic signed [DW-1:0] in_q [4];
  logic signed [DW-1:0] in_v [3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      in_q[l] = s_axis_tdata[l*DW +: DW];
    end
    for (int l = 0; l < 3; l++) begin
      in_v[l] = s_axis_tdata[(4+l)*DW +: DW];
    end
  end

  // stage 0: squares, dot-product terms and cross-product terms
  logic signed [PW-1:0] s0_sq_q [4];
  logic signed [PW-1:0] s0_dp_q [3];
  logic signed [PW-1:0] s0_cr_q [6];
  logic signed [DW-1:0] s0_q_q  [4];
  logic signed [DW-1:0] s0_v_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int l = 0; l < 4; l++) begin
        s0_sq_q[l] <= in_q[l] * in_q[l];
        s0_q_q[l]  <= in_q[l];
      end
      for (int l = 0; l < 3; l++) begin
        s0_dp_q[l] <= in_q[l] * in_v[l];
        s0_v_q[l]  <= in_v[l];
      end
      // pairs for the x, y and z cross components: y*vz, z*vy, z*vx, x*vz, x*vy, y*vx
      s0_cr_q[0] <= in_q[1] * in_v[2];
      s0_cr_q[1] <= in_q[2] * in_v[1];
      s0_cr_q[2] <= in_q[2] * in_v[0];
      s0_cr_q[3] <= in_q[0] * in_v[2];
      s0_cr_q[4] <= in_q[0] * in_v[1];
      s0_cr_q[5] <= in_q[1] * in_v[0];
    end
  end

  // stage 1: modulus, scalar term w^2 - u.u, dot product, cross product
  logic signed [DENW-1:0] s1_den_q, s1_s_q, s1_dot_q;
  logic signed [PW:0]     s1_cr_q [3];
  logic signed [DW-1:0]   s1_q_q  [4];
  logic signed [DW-1:0]   s1_v_q  [3];
  logic signed [DENW-1:0] uu;

  assign uu = DENW'(s0_sq_q[0]) + DENW'(s0_sq_q[1]) + DENW'(s0_sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_den_q <= DENW'(s0_sq_q[3]) + uu;
      s1_s_q   <= DENW'(s0_sq_q[3]) - uu;
      s1_dot_q <= DENW'(s0_dp_q[0]) + DENW'(s0_dp_q[1]) + DENW'(s0_dp_q[2]);
      for (int l = 0; l < 3; l++) begin
        s1_cr_q[l] <= (PW+1)'(s0_cr_q[2*l]) - (PW+1)'(s0_cr_q[2*l+1]);
        s1_v_q[l]  <= s0_v_q[l];
      end
      for (int l = 0; l < 4; l++) begin
        s1_q_q[l] <= s0_q_q[l];
      end
    end
  end

  // stage 2: scale v by the scalar term, u by the dot product, cross by w
  logic signed [NW-1:0]   s2_a_q [3];
  logic signed [NW-1:0]   s2_b_q [3];
  logic signed [NW-1:0]   s2_c_q [3];
  logic signed [DENW-1:0] s2_den_q;
  logic signed [MW-1:0]   pa [3];
  logic signed [MW-1:0]   pb [3];
  logic signed [MW-1:0]   pc [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      pa[l] = s1_s_q * s1_v_q[l];
      pb[l] = s1_dot_q * s1_q_q[l];
      pc[l] = s1_cr_q[l] * s1_q_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int l = 0; l < 3; l++) begin
        s2_a_q[l] <= NW'(pa[l]);
        s2_b_q[l] <= NW'(pb[l]);
        s2_c_q[l] <= NW'(pc[l]);
      end
      s2_den_q <= s1_den_q;
    end
  end

  // stage 3: numerator N = a + 2b + 2c
  logic signed [NW-1:0]   s3_n_q [3];
  logic signed [DENW-1:0] s3_den_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int l = 0; l < 3; l++) begin
        s3_n_q[l] <= s2_a_q[l] + (s2_b_q[l] <<< 1) + (s2_c_q[l] <<< 1);
      end
      s3_den_q <= s2_den_q;
    end
  end

  // divider pipeline; index 0 is the stage-4 register (sign and magnitude)
  logic [NW-1:0]   dv_rem_q  [NDS+1][3];
  logic [DW-1:0]   dv_quo_q  [NDS+1][3];
  logic [2:0]      dv_neg_q  [NDS+1];
  logic [DENW-1:0] dv_den_q  [NDS+1];
  logic            dv_zero_q [NDS+1];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int l = 0; l < 3; l++) begin
        dv_neg_q[0][l] <= s3_n_q[l][NW-1];
        dv_rem_q[0][l] <= s3_n_q[l][NW-1] ? NW'(-s3_n_q[l]) : NW'(s3_n_q[l]);
        dv_quo_q[0][l] <= '0;
      end
      dv_den_q[0]  <= s3_den_q;
      dv_zero_q[0] <= (s3_den_q == '0);
    end
  end

  logic [NW-1:0] dv_rem_d [NDS][3];
  logic [DW-1:0] dv_quo_d [NDS][3];

  for (genvar k = 0; k < NDS; k++) begin : g_div
    // restoring division, STEPS quotient bits per stage, most significant first
    always_comb begin
      logic [NW-1:0] rem;
      logic [DW-1:0] quo;
      logic [NW:0]   trial;
      int            bit_idx;
      for (int l = 0; l < 3; l++) begin
        rem = dv_rem_q[k][l];
        quo = dv_quo_q[k][l];
        for (int j = 0; j < STEPS; j++) begin
          bit_idx = int'(DW) - 1 - (k * int'(STEPS) + j);
          trial   = '0;
          if (bit_idx >= 0) begin
            trial = {1'b0, rem} - ({{(NW+1-DENW){1'b0}}, dv_den_q[k]} << bit_idx);
            if (!trial[NW]) begin
              rem = trial[NW-1:0];
              quo[bit_idx[$clog2(DW)-1:0]] = 1'b1;
            end
          end
        end
        dv_rem_d[k][l] = rem;
        dv_quo_d[k][l] = quo;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[5+k]) begin
        dv_rem_q[k+1]  <= dv_rem_d[k];
        dv_quo_q[k+1]  <= dv_quo_d[k];
        dv_neg_q[k+1]  <= dv_neg_q[k];
        dv_den_q[k+1]  <= dv_den_q[k];
        dv_zero_q[k+1] <= dv_zero_q[k];
      end
    end
  end

  // final stage: round to nearest with ties away from zero, then saturate
  localparam logic [DW:0] LIM = (DW+1)'(1) << (DW - 1);

  logic [DW-1:0] res   [3];
  logic [2:0]    sat_l;
  logic [DW-1:0] out_q [3];
  logic          zero_q, sat_q;

  always_comb begin
    logic          up;
    logic [DW:0]   q1;
    for (int l = 0; l < 3; l++) begin
      up       = {dv_rem_q[NDS][l][DENW-1:0], 1'b0} >= {1'b0, dv_den_q[NDS]};
      q1       = {1'b0, dv_quo_q[NDS][l]} + (DW+1)'(up);
      sat_l[l] = 1'b0;
      if (dv_zero_q[NDS]) begin
        res[l] = '0;
      end else if (dv_neg_q[NDS][l]) begin
        if (q1 > LIM) begin
          res[l]   = LIM[DW-1:0];
          sat_l[l] = 1'b1;
        end else begin
          res[l] = DW'(-q1);
        end
      end else begin
        if (q1 > LIM - 1'b1) begin
          res[l]   = DW'(LIM - 1'b1);
          sat_l[l] = 1'b1;
        end else begin
          res[l] = q1[DW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q  <= res;
      zero_q <= dv_zero_q[NDS];
      sat_q  <= |sat_l;
    end
  end

  assign m_axis_tvalid = vld_q[NS-1];

  always_comb begin
    m_axis_tdata = '0;
    for (int l = 0; l < 3; l++) begin
      m_axis_tdata[l*DW +: DW] = out_q[l];
    end
    m_axis_tuser = '0;
    m_axis_tuser[qvr_pkg::USER_ZERO_BIT] = zero_q;
    m_axis_tuser[qvr_pkg::USER_SAT_BIT]  = sat_q;
  end

endmodule

// ===== design/qvr_checker.sv =====
// Port-level checker for the quaternion vector rotation block, and its bind.
// Depends on qvr_pkg for defaults and tuser bit positions.
module qvr_checker #(
  parameter int unsigned DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [((7*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic [qvr_pkg::USER_WIDTH-1:0]    m_axis_tuser
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam logic [DW-1:0] PMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] NMIN = {1'b1, {(DW-1){1'b0}}};

  logic zero_f, sat_f;
  logic [DW-1:0] ox, oy, oz;

  assign zero_f = m_axis_tuser[qvr_pkg::USER_ZERO_BIT];
  assign sat_f  = m_axis_tuser[qvr_pkg::USER_SAT_BIT];
  assign ox     = m_axis_tdata[DW-1:0];
  assign oy     = m_axis_tdata[2*DW-1:DW];
  assign oz     = m_axis_tdata[3*DW-1:2*DW];

  // no result may appear while reset is applied
  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // zero quaternion gives zero components and no saturation
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && zero_f |-> (ox == '0) && (oy == '0) && (oz == '0) && !sat_f)
    else $error("zero quaternion with nonzero result");

  // saturation leaves at least one component at a limit
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sat_f |->
      (ox == PMAX) || (ox == NMIN) || (oy == PMAX) || (oy == NMIN) ||
      (oz == PMAX) || (oz == NMIN))
    else $error("saturation flag without a clipped component");

endmodule

bind quaternion_vector_rotate qvr_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qvr_checker (.*);

// ===== tb/quaternion_vector_rotate_tb.sv =====
// Self-checking testbench for the quaternion vector rotation block.
// Predicts each rotated vector in exact integer arithmetic; depends on qvr_pkg
// and design/quaternion_vector_rotate.sv.
module quaternion_vector_rotate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW = qvr_pkg::DATA_WIDTH_DEF;
  localparam int unsigned IN_W = ((7*DW+7)/8)*8;
  localparam int unsigned OUT_W = ((3*DW+7)/8)*8;
  localparam int unsigned LATENCY = 6 + (DW+1)/2;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [DW-1:0] ox, oy, oz;
    logic zero_q, sat;
  } rot_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z from bit 0 up
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // out_x, out_y, out_z from bit 0 up
  logic [OUT_W-1:0] m_axis_tdata;
  // zero_quaternion, saturated from bit 0 up
  logic [qvr_pkg::USER_WIDTH-1:0] m_axis_tuser;

  quaternion_vector_rotate #(.DATA_WIDTH(DW)) uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  rot_t expected_rot[$];
  int mismatches = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;      // random idling enabled on both sides
  int hold_reqs = 0;       // hold-off requests issued by the tests
  int hold_seen = 0;       // hold-off requests taken up by the receiver
  int hold_off = 0;        // cycles left for which the receiver refuses items

  // Round num/den to nearest, ties away from zero, and clip to DW signed bits.
  function automatic logic [DW-1:0] round_clip(longint num, longint den, ref bit sat);
    longint mag, quo, rem;
    mag = num < 0 ? -num : num;
    quo = mag / den;
    rem = mag % den;
    if (rem >= den - rem) quo++;
    if (num < 0) begin
      if (quo > (64'sd1 << (DW-1))) begin
        quo = 64'sd1 << (DW-1);
        sat = 1'b1;
      end
      return DW'(-quo);
    end
    if (quo > (64'sd1 << (DW-1)) - 1) begin
      quo = (64'sd1 << (DW-1)) - 1;
      sat = 1'b1;
    end
    return DW'(quo);
  endfunction

  // Rotate v by q: (w^2 - u.u) v + 2(u.v) u + 2w (u x v), over |q|^2.
  function automatic rot_t rotate_vec(logic [IN_W-1:0] d);
    longint qx, qy, qz, qw, vx, vy, vz, uu, den, s, d2, w2;
    bit sat;
    rot_t r;
    qx = longint'($signed(d[0*DW +: DW]));
    qy = longint'($signed(d[1*DW +: DW]));
    qz = longint'($signed(d[2*DW +: DW]));
    qw = longint'($signed(d[3*DW +: DW]));
    vx = longint'($signed(d[4*DW +: DW]));
    vy = longint'($signed(d[5*DW +: DW]));
    vz = longint'($signed(d[6*DW +: DW]));
    sat = 1'b0;
    r = '0;
    uu = qx*qx + qy*qy + qz*qz;
    den = qw*qw + uu;
    if (den == 0) begin
      r.zero_q = 1'b1;
      return r;
    end
    s = qw*qw - uu;
    d2 = 2 * (qx*vx + qy*vy + qz*vz);
    w2 = 2 * qw;
    r.ox = round_clip(s*vx + d2*qx + w2*(qy*vz - qz*vy), den, sat);
    r.oy = round_clip(s*vy + d2*qy + w2*(qz*vx - qx*vz), den, sat);
    r.oz = round_clip(s*vz + d2*qz + w2*(qx*vy - qy*vx), den, sat);
    r.sat = sat;
    return r;
  endfunction

  // Offer one item and hold it until accepted; valid stays up for the next one.
  task automatic send_item(int qx, qy, qz, qw, vx, vy, vz);
    while (idle_on && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({DW'(vz), DW'(vy), DW'(vx), DW'(qw), DW'(qz), DW'(qy),
                           DW'(qx)});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_rot.push_back(rotate_vec(s_axis_tdata));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_rot.size() != 0) @(posedge clk_i);
  endtask

  function automatic int rnd_field();
    case ($urandom_range(5))
      0: return (1 << (DW-1)) - 1;
      1: return -(1 << (DW-1));
      2: return int'($urandom_range(7)) - 3;
      default: return int'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, plus the long hold-off when requested.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_off <= 4 * LATENCY + 20;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
    m_axis_tready <= rst_ni && hold_off <= 1 && hold_reqs == hold_seen &&
                     !(idle_on && $urandom_range(99) < 7);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    rot_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0 +: DW], m_axis_tdata[DW +: DW], m_axis_tdata[2*DW +: DW],
             m_axis_tuser[qvr_pkg::USER_ZERO_BIT], m_axis_tuser[qvr_pkg::USER_SAT_BIT]};
      if (expected_rot.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_rot.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: x %h/%h y %h/%h z %h/%h zero %b/%b sat %b/%b (exp/act)",
                     want.ox, got.ox, want.oy, got.oy, want.oz, got.oz,
                     want.zero_q, got.zero_q, want.sat, got.sat);
        end
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL quaternion_vector_rotate");
      $finish;
    end
  end

  localparam int MAXV = (1 << (DW-1)) - 1;
  localparam int MINV = -(1 << (DW-1));
  localparam int ONE = 1 << 14;

  // Corners: identity, zero quaternion, extremes, 90-degree turns, scaled and
  // negative quaternions, rounding ties.
  task automatic test_directed();
    send_item(0, 0, 0, ONE, 100, -200, 300);
    send_item(0, 0, 0, 0, 5, 6, 7);
    send_item(0, 0, 0, 0, MAXV, MINV, MAXV);
    send_item(0, 0, 0, MINV, MINV, MAXV, MINV);
    send_item(0, 0, 0, MAXV, MAXV, MAXV, MAXV);
    send_item(MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV);
    send_item(MINV, MINV, MINV, MINV, MAXV, MINV, MAXV);
    send_item(MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV);
    send_item(0, 0, 11585, 11585, MAXV, 0, 0);
    send_item(11585, 0, 0, 11585, MINV, MINV, MINV);
    send_item(0, 11585, 0, 11585, MINV, MAXV, MINV);
    send_item(ONE, 0, 0, 0, MINV, 1, 1);
    send_item(0, ONE, 0, 0, MAXV, MINV, 0);
    send_item(0, 0, ONE, 0, 7, -7, MINV);
    send_item(1, 1, 0, 0, 1, 0, 0);
    send_item(1, 1, 1, 1, 1, 0, 0);
    send_item(1, 0, 0, 1, 0, 1, 1);
    send_item(0, 0, 1, 0, 3, 0, 0);
    send_item(-1, 0, 0, 0, -1, -1, -1);
    send_item(100, -3, 7, 0, MAXV, MAXV, MAXV);
    send_item(0, 0, 0, -1, -32, 17, -9);
  endtask

  // Random items with full-range corners mixed in.
  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_item(rnd_field(), rnd_field(), rnd_field(), rnd_field(),
                rnd_field(), rnd_field(), rnd_field());
  endtask

  // Back-to-back items with no idling on either side.
  task automatic test_streaming(int n);
    idle_on = 1'b0;
    test_random(n);
    idle_on = 1'b1;
  endtask

  // Hold the receiver off long enough that the pipeline fills and stalls input.
  task automatic test_backpressure();
    hold_reqs++;
    test_random(3 * LATENCY);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random(500);
    test_streaming(300);
    test_backpressure();
    wait_drained();
    test_random(350);
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && expected_rot.size() == 0) begin
      $display("PASS quaternion_vector_rotate");
    end else begin
      $display("FAIL quaternion_vector_rotate");
    end
    $finish;
  end
endmodule
